FILE: rtl/bms_pkg.sv
// Shared types and constants for the 3x3 box mean smoothing unit.
// No dependencies; used by every other file of the block.
package bms_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int WIDTH_REG_W = 12;
	localparam int HEIGHT_REG_W = 13;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_DIM      = 3;

	localparam int SAMPLE_W = 8;
	localparam int SUM_W    = 12;

	// floor(s / 9) == (s * MEAN_RECIP) >> MEAN_SHIFT for every sum of nine samples
	localparam int MEAN_RECIP   = 7282;
	localparam int MEAN_RECIP_W = 13;
	localparam int MEAN_SHIFT   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] blue;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] red;
	} rgb_t;

	typedef struct packed {
		logic [SUM_W-1:0] blue;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] red;
	} sum_t;

endpackage

FILE: rtl/bms_line_buf.sv
// Two line stores (upper and middle row) with registered read and write bypass.
// Depends on bms_pkg for the pixel word type.
module bms_line_buf #(
	parameter int DEPTH = bms_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  bms_pkg::rgb_t            wr_upper,
	input  bms_pkg::rgb_t            wr_middle,
	output bms_pkg::rgb_t            rd_upper,
	output bms_pkg::rgb_t            rd_middle
);

	bms_pkg::rgb_t upper_mem [DEPTH];
	bms_pkg::rgb_t middle_mem [DEPTH];
	bms_pkg::rgb_t upper_q;
	bms_pkg::rgb_t middle_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	// forward a write that lands on the address being read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				upper_q  <= wr_upper;
				middle_q <= wr_middle;
			end else begin
				upper_q  <= upper_mem[rd_addr];
				middle_q <= middle_mem[rd_addr];
			end
		end
	end

	assign rd_upper  = upper_q;
	assign rd_middle = middle_q;

endmodule

FILE: rtl/bms_window.sv
// 3x3 neighborhood register with per-channel sums of the shifted-in window.
// Depends on bms_pkg for pixel and sum types.
module bms_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  bms_pkg::rgb_t col_upper,
	input  bms_pkg::rgb_t col_middle,
	input  bms_pkg::rgb_t col_lower,
	output bms_pkg::sum_t sum,
	output bms_pkg::rgb_t center
);

	localparam int ROW_W = bms_pkg::SAMPLE_W + 2;

	bms_pkg::rgb_t win_q [9];
	bms_pkg::rgb_t win_nx [9];
	logic [ROW_W-1:0] row_r [3];
	logic [ROW_W-1:0] row_g [3];
	logic [ROW_W-1:0] row_b [3];

	// cell index row*3+col, col 2 newest, row 2 current line
	always_comb begin
		win_nx[0] = win_q[1];
		win_nx[1] = win_q[2];
		win_nx[2] = col_upper;
		win_nx[3] = win_q[4];
		win_nx[4] = win_q[5];
		win_nx[5] = col_middle;
		win_nx[6] = win_q[7];
		win_nx[7] = win_q[8];
		win_nx[8] = col_lower;
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_r[r] = ROW_W'(win_nx[r*3].red) + ROW_W'(win_nx[r*3+1].red)
				+ ROW_W'(win_nx[r*3+2].red);
			row_g[r] = ROW_W'(win_nx[r*3].green) + ROW_W'(win_nx[r*3+1].green)
				+ ROW_W'(win_nx[r*3+2].green);
			row_b[r] = ROW_W'(win_nx[r*3].blue) + ROW_W'(win_nx[r*3+1].blue)
				+ ROW_W'(win_nx[r*3+2].blue);
		end
		sum.red   = bms_pkg::SUM_W'(row_r[0]) + bms_pkg::SUM_W'(row_r[1])
			+ bms_pkg::SUM_W'(row_r[2]);
		sum.green = bms_pkg::SUM_W'(row_g[0]) + bms_pkg::SUM_W'(row_g[1])
			+ bms_pkg::SUM_W'(row_g[2]);
		sum.blue  = bms_pkg::SUM_W'(row_b[0]) + bms_pkg::SUM_W'(row_b[1])
			+ bms_pkg::SUM_W'(row_b[2]);
	end

	assign center = win_nx[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= win_nx[k];
			end
		end
	end

endmodule

FILE: rtl/box_mean_3x3_smoothing_unit.sv
// Top level of the 3x3 box mean smoothing unit: position control, pipeline, divide by nine.
// Depends on bms_pkg, bms_line_buf and bms_window.
//
// Usage:
// The input channel takes one RGB pixel word per cycle in raster order (in_valid/in_stall).
// A word with flush set carries no pixel; after the last pixel of a frame, each flush
// word drains one remaining result. Pixels of a following frame push the tail out too.
// The output channel (out_valid/out_stall) gives one smoothed pixel per result in raster
// order, one image row plus one pixel behind the input; frame_last marks the final pixel.
// Interior pixels carry the truncated 3x3 mean per channel; border rows and columns pass
// through unchanged.
// Pipeline: three register stages (pixel register with line store read, window sum,
// output register) lie between the word that releases a result and the output.
// Throughput: one word per cycle while in_stall is low, set by the single read and write port of each line store.
// A stall on the output holds the output register; the two inner stages keep taking words
// until they fill, then in_stall rises.
// Reset clears positions, the pending count, the window and the pipeline, and sets width
// 640 and height 480; the line stores are not cleared. Write image_width and image_height
// only while the unit is idle.
module box_mean_3x3_smoothing_unit #(
	parameter int MAX_WIDTH  = bms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bms_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bms_pkg::SAMPLE_W-1:0]    in_red,
	input  logic [bms_pkg::SAMPLE_W-1:0]    in_green,
	input  logic [bms_pkg::SAMPLE_W-1:0]    in_blue,
	input  logic                            flush,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bms_pkg::SAMPLE_W-1:0]    out_red,
	output logic [bms_pkg::SAMPLE_W-1:0]    out_green,
	output logic [bms_pkg::SAMPLE_W-1:0]    out_blue,
	output logic                            frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int RST_W = (bms_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
		: bms_pkg::WIDTH_RESET;
	localparam int RST_H = (bms_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
		: bms_pkg::HEIGHT_RESET;
	localparam int PRODW = bms_pkg::SUM_W + bms_pkg::MEAN_RECIP_W;
	localparam int MS = bms_pkg::MEAN_SHIFT;

	typedef struct packed {
		logic is_pix;
		logic emit;
		logic interior;
		logic last;
		logic use_upper;
	} s1_ctl_t;

	// configuration, held clamped
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [WW-1:0] w_new;
	logic [HW-1:0] h_new;
	logic [bms_pkg::WIDTH_REG_W-1:0]  w_raw;
	logic [bms_pkg::HEIGHT_REG_W-1:0] h_raw;

	// positions and pending count
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [RW-1:0] out_row_q;
	logic [PW-1:0] pend_q;

	logic          frame_start;
	logic          pend_full;
	logic          restart;
	logic          emit_fl;
	logic          emit;
	logic          load;
	logic          acc;
	logic [CW-1:0] oc_eff;
	logic [RW-1:0] or_eff;
	logic [PW-1:0] pe_eff;
	logic [CW:0]   in_col_inc;
	logic [RW:0]   in_row_inc;
	logic [CW:0]   oc_inc;
	logic [RW:0]   or_inc;
	logic [CW-1:0] in_col_nx;
	logic [RW-1:0] in_row_nx;
	logic [CW-1:0] oc_nx;
	logic [RW-1:0] or_nx;
	logic          last_now;
	logic          interior_now;

	// pipeline
	logic          out_rdy;
	logic          s2_rdy;
	logic          s1_rdy;
	logic          s1_v;
	s1_ctl_t       s1_ctl;
	logic [CW-1:0] s1_addr;
	bms_pkg::rgb_t s1_pix;
	bms_pkg::rgb_t rd_upper;
	bms_pkg::rgb_t rd_middle;
	logic          s1_adv;
	logic          line_wr;
	bms_pkg::sum_t win_sum;
	bms_pkg::rgb_t win_center;

	logic          s2_v;
	bms_pkg::sum_t s2_sum;
	bms_pkg::rgb_t s2_pass;
	logic          s2_int;
	logic          s2_last;

	logic [PRODW-1:0] prod_r;
	logic [PRODW-1:0] prod_g;
	logic [PRODW-1:0] prod_b;
	bms_pkg::rgb_t    mean;

	logic          out_v_q;
	bms_pkg::rgb_t out_pix_q;
	logic          out_last_q;

	// configuration write
	assign w_raw = cfg_data[bms_pkg::WIDTH_REG_W-1:0];
	assign h_raw = cfg_data[bms_pkg::HEIGHT_REG_W-1:0];

	always_comb begin
		if (32'(w_raw) < bms_pkg::MIN_DIM) begin
			w_new = WW'(bms_pkg::MIN_DIM);
		end else if (32'(w_raw) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(w_raw);
		end
		if (32'(h_raw) < bms_pkg::MIN_DIM) begin
			h_new = HW'(bms_pkg::MIN_DIM);
		end else if (32'(h_raw) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(h_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(RST_W);
			h_q <= HW'(RST_H);
		end else if (cfg_write) begin
			unique case (bms_pkg::cfg_reg_t'(cfg_index))
				bms_pkg::REG_IMAGE_WIDTH:  w_q <= w_new;
				bms_pkg::REG_IMAGE_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	// handshake
	assign out_rdy  = !out_v_q || !out_stall;
	assign s2_rdy   = !s2_v || out_rdy;
	assign s1_rdy   = !s1_v || s2_rdy;
	assign in_stall = !s1_rdy;
	assign acc      = in_valid && s1_rdy;

	// position control
	always_comb begin
		frame_start = (in_col_q == '0) && (in_row_q == '0);
		pend_full   = (PW+1)'(pend_q) >= ((PW+1)'(w_q) + (PW+1)'(1));
		restart     = !flush && frame_start && (pend_q != '0) && !pend_full;
		emit_fl     = frame_start && (pend_q != '0);
		emit        = flush ? emit_fl : pend_full;
		load        = !flush || emit_fl;

		oc_eff = restart ? '0 : out_col_q;
		or_eff = restart ? '0 : out_row_q;
		pe_eff = restart ? '0 : pend_q;

		in_col_inc = (CW+1)'(in_col_q) + (CW+1)'(1);
		in_row_inc = (RW+1)'(in_row_q) + (RW+1)'(1);
		if (in_col_inc >= (CW+1)'(w_q)) begin
			in_col_nx = '0;
			in_row_nx = (in_row_inc >= (RW+1)'(h_q)) ? '0 : in_row_inc[RW-1:0];
		end else begin
			in_col_nx = in_col_inc[CW-1:0];
			in_row_nx = in_row_q;
		end

		oc_inc = (CW+1)'(oc_eff) + (CW+1)'(1);
		or_inc = (RW+1)'(or_eff) + (RW+1)'(1);
		if (oc_inc >= (CW+1)'(w_q)) begin
			oc_nx = '0;
			or_nx = (or_inc >= (RW+1)'(h_q)) ? '0 : or_inc[RW-1:0];
		end else begin
			oc_nx = oc_inc[CW-1:0];
			or_nx = or_eff;
		end

		last_now     = (or_inc == (RW+1)'(h_q)) && (oc_inc == (CW+1)'(w_q));
		interior_now = (or_eff != '0) && (or_inc < (RW+1)'(h_q))
			&& (oc_eff != '0) && (oc_inc < (CW+1)'(w_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
		end else if (acc) begin
			if (!flush) begin
				in_col_q <= in_col_nx;
				in_row_q <= in_row_nx;
			end
			if (emit) begin
				out_col_q <= oc_nx;
				out_row_q <= or_nx;
			end else if (restart) begin
				out_col_q <= '0;
				out_row_q <= '0;
			end
			if (flush) begin
				if (emit_fl) begin
					pend_q <= pend_q - PW'(1);
				end
			end else if (!pend_full) begin
				pend_q <= pe_eff + PW'(1);
			end
		end
	end

	// stage 1: pixel register, line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_rdy) begin
			s1_v <= acc && load;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && load) begin
			s1_ctl.is_pix    <= !flush;
			s1_ctl.emit      <= emit;
			s1_ctl.interior  <= interior_now && !flush;
			s1_ctl.last      <= last_now;
			s1_ctl.use_upper <= pend_full;
			s1_addr          <= flush ? out_col_q : in_col_q;
			s1_pix           <= '{blue: in_blue, green: in_green, red: in_red};
		end
	end

	assign s1_adv  = s1_v && s2_rdy;
	assign line_wr = s1_adv && s1_ctl.is_pix;

	bms_line_buf #(
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk       (clk),
		.rd_en     (acc && load),
		.rd_addr   (flush ? out_col_q : in_col_q),
		.wr_en     (line_wr),
		.wr_addr   (s1_addr),
		.wr_upper  (rd_middle),
		.wr_middle (s1_pix),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle)
	);

	bms_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift      (line_wr),
		.col_upper  (rd_upper),
		.col_middle (rd_middle),
		.col_lower  (s1_pix),
		.sum        (win_sum),
		.center     (win_center)
	);

	// stage 2: window sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s2_rdy) begin
			s2_v <= s1_v && s1_ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_sum  <= win_sum;
			s2_int  <= s1_ctl.interior;
			s2_last <= s1_ctl.last;
			if (s1_ctl.is_pix) begin
				s2_pass <= win_center;
			end else begin
				s2_pass <= s1_ctl.use_upper ? rd_upper : rd_middle;
			end
		end
	end

	// divide by nine
	always_comb begin
		prod_r = PRODW'(s2_sum.red) * PRODW'(bms_pkg::MEAN_RECIP);
		prod_g = PRODW'(s2_sum.green) * PRODW'(bms_pkg::MEAN_RECIP);
		prod_b = PRODW'(s2_sum.blue) * PRODW'(bms_pkg::MEAN_RECIP);
		mean.red   = prod_r[MS+bms_pkg::SAMPLE_W-1:MS];
		mean.green = prod_g[MS+bms_pkg::SAMPLE_W-1:MS];
		mean.blue  = prod_b[MS+bms_pkg::SAMPLE_W-1:MS];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && s2_v) begin
			out_pix_q  <= s2_int ? mean : s2_pass;
			out_last_q <= s2_last;
		end
	end

	assign out_valid  = out_v_q;
	assign out_red    = out_pix_q.red;
	assign out_green  = out_pix_q.green;
	assign out_blue   = out_pix_q.blue;
	assign frame_last = out_last_q;

endmodule
